@@ hw/rtl/fss_pkg.sv @@
`default_nettype none

package fss_pkg;

  // Fixed field widths.
  localparam int BYTE_W     = 8;
  localparam int QPOS_W     = 5;
  localparam int IDX_W      = 13;
  localparam int SCORE_W    = 14;
  localparam int START_W    = 12;
  localparam int SPAN_W     = 13;
  localparam int RS_W       = 9;   // running score peaks at 16 hits of 18 points
  localparam int RUN_W      = 5;   // a run never exceeds the query length
  localparam int QUERY_BYTES = 16;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_ENTRY_LEN = 4096;
  localparam int DEF_HISTORY_LIMIT = 5000;

  // Depth of the queue between the scanner and the finisher.
  localparam int SUM_QUEUE_DEPTH = 2;

  // Scoring constants.
  localparam int HIT_POINTS    = 1;
  localparam int RUN_BONUS     = 5;
  localparam int SEP_BONUS     = 10;
  localparam int CASE_BONUS    = 2;
  localparam int BEST_RUN_MULT = 3;
  localparam int EMPTY_SCORE   = 100;

  // Division by ten as a multiply by 52429 and a shift by 19; exact below 2**18.
  localparam int DIV10_MUL_W = 16;
  localparam int DIV10_SHIFT = 19;
  localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 16'd52429;

  // Character codes.
  localparam logic [BYTE_W-1:0] CH_UPPER_A  = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [BYTE_W-1:0] FOLD_OFFSET = 8'h20;
  localparam logic [BYTE_W-1:0] CH_SPACE    = 8'h20;
  localparam logic [BYTE_W-1:0] CH_SLASH    = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_DASH     = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_UNDER    = 8'h5F;

  // Configuration port.
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 64;
  localparam int REG_IDX_W  = 2;
  localparam logic [REG_IDX_W-1:0] REG_QUERY_LEN  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_QUERY_LOW  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_QUERY_HIGH = 2'd2;

  typedef logic [QUERY_BYTES-1:0][BYTE_W-1:0] qbytes_t;

  // Width of the byte counter, which must hold the maximum length itself.
  function automatic int cnt_width(input int max_len);
    return $clog2(max_len + 1);
  endfunction

  // Width of a byte offset inside an entry.
  function automatic int off_width(input int max_len);
    return $clog2(max_len);
  endfunction

  // Width of one entry summary word handed from scanner to finisher.
  function automatic int sum_width(input int max_len);
    return 3 + IDX_W + RS_W + RUN_W + 2 * off_width(max_len) + cnt_width(max_len);
  endfunction

  // Fold ASCII uppercase to lowercase.
  function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] c);
    return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + FOLD_OFFSET : c;
  endfunction

  // Characters after which a match earns the word-start bonus.
  function automatic logic is_sep(input logic [BYTE_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_SLASH) || (c == CH_DASH) || (c == CH_UNDER);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/fss_if.sv @@
`default_nettype none

// Entry byte stream.
interface fss_in_if import fss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] entry_byte;
  logic              has_byte;
  logic              entry_end;
  logic [IDX_W-1:0]  entry_index;

  modport source (output valid, entry_byte, has_byte, entry_end, entry_index,
                  input ready);
  modport sink (input valid, entry_byte, has_byte, entry_end, entry_index,
                output ready);
endinterface

// Score results.
interface fss_out_if import fss_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      matched;
  logic signed [SCORE_W-1:0] match_score;
  logic [START_W-1:0]        match_start;
  logic [SPAN_W-1:0]         match_span;
  logic [IDX_W-1:0]          scored_index;

  modport source (output valid, matched, match_score, match_start, match_span,
                  scored_index, input ready);
  modport sink (input valid, matched, match_score, match_start, match_span,
                scored_index, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/fss_front.sv @@
`default_nettype none

module fss_front import fss_pkg::*; #(
  parameter int MAX_ENTRY_LEN = DEF_MAX_ENTRY_LEN,
  parameter int HISTORY_LIMIT = DEF_HISTORY_LIMIT,
  localparam int CNT_W = cnt_width(MAX_ENTRY_LEN),
  localparam int OFF_W = off_width(MAX_ENTRY_LEN),
  localparam int SUM_W = sum_width(MAX_ENTRY_LEN)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  fss_in_if.sink                 entry,
  input  wire logic [QPOS_W-1:0] query_len,
  input  wire qbytes_t           query_bytes,
  input  wire logic              sum_full,
  output logic                   sum_push,
  output logic [SUM_W-1:0]       sum_data
);

  // Per-entry scan state.
  logic [QPOS_W-1:0] query_pos, query_pos_next;
  logic              in_run, in_run_next;
  logic [RUN_W-1:0]  run_len, run_len_next;
  logic [RUN_W-1:0]  best_run, best_run_next;
  logic              has_hit, has_hit_next;
  logic [OFF_W-1:0]  first_hit, first_hit_next;
  logic [OFF_W-1:0]  last_hit, last_hit_next;
  logic [RS_W-1:0]   running_score, running_score_next;
  logic [BYTE_W-1:0] prev_byte, prev_byte_next;
  logic [CNT_W-1:0]  byte_count, byte_count_next;

  logic              accept;
  logic [QPOS_W-1:0] active_len;
  logic [BYTE_W-1:0] q_byte;
  logic              in_range;
  logic              live;
  logic              hit;
  logic              miss;
  logic [RS_W-1:0]   hit_points;
  logic [RUN_W-1:0]  best_final;
  logic              empty_query;
  logic              consumed;
  logic              in_hist;

  assign entry.ready = !sum_full;
  assign accept      = entry.valid && entry.ready;

  // Query length above the byte count acts as a full query.
  assign active_len = (query_len > QPOS_W'(QUERY_BYTES)) ? QPOS_W'(QUERY_BYTES) : query_len;
  assign q_byte     = query_bytes[query_pos[QPOS_W-2:0]];
  assign in_range   = byte_count < CNT_W'(MAX_ENTRY_LEN);

  // A byte takes part in matching only while the query is not yet consumed.
  assign live = entry.has_byte && in_range && (query_pos < active_len);
  assign hit  = live && (fold(entry.entry_byte) == fold(q_byte));
  assign miss = live && !hit;

  // Points for one matched byte.
  always_comb begin
    hit_points = RS_W'(HIT_POINTS);
    if (in_run) begin
      hit_points = hit_points + RS_W'(RUN_BONUS);
    end
    if (byte_count == '0 || is_sep(prev_byte)) begin
      hit_points = hit_points + RS_W'(SEP_BONUS);
    end
    if (entry.entry_byte == q_byte) begin
      hit_points = hit_points + RS_W'(CASE_BONUS);
    end
  end

  // Next scan state after this item's byte.
  always_comb begin
    query_pos_next     = query_pos;
    in_run_next        = in_run;
    run_len_next       = run_len;
    best_run_next      = best_run;
    has_hit_next       = has_hit;
    first_hit_next     = first_hit;
    last_hit_next      = last_hit;
    running_score_next = running_score;
    prev_byte_next     = prev_byte;
    byte_count_next    = byte_count;
    if (hit) begin
      query_pos_next     = query_pos + 1'b1;
      in_run_next        = 1'b1;
      run_len_next       = in_run ? run_len + 1'b1 : RUN_W'(1);
      has_hit_next       = 1'b1;
      first_hit_next     = has_hit ? first_hit : byte_count[OFF_W-1:0];
      last_hit_next      = byte_count[OFF_W-1:0];
      running_score_next = running_score + hit_points;
    end else if (miss) begin
      in_run_next   = 1'b0;
      run_len_next  = '0;
      best_run_next = (run_len > best_run) ? run_len : best_run;
    end
    if (entry.has_byte) begin
      prev_byte_next = entry.entry_byte;
      if (in_range) begin
        byte_count_next = byte_count + 1'b1;
      end
    end
  end

  // Entry summary handed to the finisher at the end word.
  assign best_final  = (run_len_next > best_run_next) ? run_len_next : best_run_next;
  assign empty_query = (active_len == '0);
  assign consumed    = (query_pos_next >= active_len);
  assign in_hist     = (32'(entry.entry_index) < 32'(HISTORY_LIMIT));
  assign sum_push    = accept && entry.entry_end;
  assign sum_data    = {empty_query, consumed, in_hist, entry.entry_index, running_score_next,
                        best_final, first_hit_next, last_hit_next, byte_count_next};

  // State register; the end word returns everything to its cleared value.
  always_ff @(posedge clk) begin
    if (rst || (accept && entry.entry_end)) begin
      query_pos     <= '0;
      in_run        <= 1'b0;
      run_len       <= '0;
      best_run      <= '0;
      has_hit       <= 1'b0;
      first_hit     <= '0;
      last_hit      <= '0;
      running_score <= '0;
      prev_byte     <= '0;
      byte_count    <= '0;
    end else if (accept) begin
      query_pos     <= query_pos_next;
      in_run        <= in_run_next;
      run_len       <= run_len_next;
      best_run      <= best_run_next;
      has_hit       <= has_hit_next;
      first_hit     <= first_hit_next;
      last_hit      <= last_hit_next;
      running_score <= running_score_next;
      prev_byte     <= prev_byte_next;
      byte_count    <= byte_count_next;
    end
  end

  // The scan state is clean for the word after an entry end.
  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    (accept && entry.entry_end) |=> (query_pos == '0 && byte_count == '0 && !in_run))
    else $error("scan state not cleared after entry end");

  // The byte counter saturates at the maximum entry length.
  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CNT_W'(MAX_ENTRY_LEN))
    else $error("byte counter passed the maximum entry length");

  // A hit offset exists whenever part of the query has matched.
  a_hit_seen: assert property (@(posedge clk) disable iff (rst)
    (query_pos != '0) |-> has_hit)
    else $error("query advanced without a recorded hit");

endmodule

`default_nettype wire

@@ hw/rtl/fss_queue.sv @@
`default_nettype none

module fss_queue import fss_pkg::*; #(
  parameter int WIDTH = 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  not_empty
);

  localparam int PTR_W = (SUM_QUEUE_DEPTH > 1) ? $clog2(SUM_QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(SUM_QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [SUM_QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(SUM_QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(SUM_QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(SUM_QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/fss_back.sv @@
`default_nettype none

module fss_back import fss_pkg::*; #(
  parameter int MAX_ENTRY_LEN = DEF_MAX_ENTRY_LEN,
  localparam int CNT_W  = cnt_width(MAX_ENTRY_LEN),
  localparam int OFF_W  = off_width(MAX_ENTRY_LEN),
  localparam int SUM_W  = sum_width(MAX_ENTRY_LEN),
  localparam int PC_W   = CNT_W + DIV10_MUL_W,
  localparam int PI_W   = IDX_W + DIV10_MUL_W,
  localparam int QC_W   = PC_W - DIV10_SHIFT,
  localparam int QI_W   = PI_W - DIV10_SHIFT,
  localparam int PRE_W  = ((CNT_W > RS_W) ? CNT_W : RS_W) + 2,
  localparam int FIN_W  = (PRE_W > SCORE_W) ? PRE_W : SCORE_W
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             sum_valid,
  input  wire logic [SUM_W-1:0] sum_data,
  output logic                  sum_pop,
  fss_out_if.source             result
);

  // Unpacked summary word.
  logic              h_empty;
  logic              h_consumed;
  logic              h_hist;
  logic [IDX_W-1:0]  h_idx;
  logic [RS_W-1:0]   h_rs;
  logic [RUN_W-1:0]  h_best;
  logic [OFF_W-1:0]  h_first;
  logic [OFF_W-1:0]  h_last;
  logic [CNT_W-1:0]  h_cnt;

  // Stage 1: span and the two divide-by-ten products.
  logic              s1_v;
  logic              s1_empty;
  logic              s1_consumed;
  logic              s1_hist;
  logic [IDX_W-1:0]  s1_idx;
  logic [RS_W-1:0]   s1_rs;
  logic [RUN_W-1:0]  s1_best;
  logic [OFF_W-1:0]  s1_first;
  logic [CNT_W-1:0]  s1_span;
  logic [PC_W-1:0]   s1_pc;
  logic [PI_W-1:0]   s1_pi;

  // Stage 2: score before the index bonus.
  logic                    s2_v;
  logic                    s2_empty;
  logic                    s2_consumed;
  logic                    s2_hist;
  logic [IDX_W-1:0]        s2_idx;
  logic [OFF_W-1:0]        s2_first;
  logic [CNT_W-1:0]        s2_span;
  logic [QI_W-1:0]         s2_qidx;
  logic signed [PRE_W-1:0] s2_pre;

  logic                    en1;
  logic                    en2;
  logic                    en3;
  logic [QC_W-1:0]         q_cnt;
  logic signed [PRE_W-1:0] pre_c;
  logic                    ok;
  logic [FIN_W-1:0]        fin_sum;

  assign {h_empty, h_consumed, h_hist, h_idx, h_rs, h_best, h_first, h_last, h_cnt} = sum_data;

  // Each stage moves when the one after it has room.
  assign en3     = !result.valid || result.ready;
  assign en2     = !s2_v || en3;
  assign en1     = !s1_v || en2;
  assign sum_pop = sum_valid && en1;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_empty    <= h_empty;
      s1_consumed <= h_consumed;
      s1_hist     <= h_hist;
      s1_idx      <= h_idx;
      s1_rs       <= h_rs;
      s1_best     <= h_best;
      s1_first    <= h_first;
      s1_span     <= CNT_W'(h_last) - CNT_W'(h_first) + 1'b1;
      s1_pc       <= PC_W'(h_cnt) * PC_W'(DIV10_MUL);
      s1_pi       <= PI_W'(h_idx) * PI_W'(DIV10_MUL);
    end
  end

  // Combine the score terms.
  assign q_cnt = s1_pc[PC_W-1:DIV10_SHIFT];
  assign pre_c = signed'(PRE_W'(s1_rs) + PRE_W'(s1_best) * PRE_W'(BEST_RUN_MULT)
                 - PRE_W'(s1_span >> 1) - PRE_W'(q_cnt));

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_empty    <= s1_empty;
      s2_consumed <= s1_consumed;
      s2_hist     <= s1_hist;
      s2_idx      <= s1_idx;
      s2_first    <= s1_first;
      s2_span     <= s1_span;
      s2_qidx     <= s1_pi[PI_W-1:DIV10_SHIFT];
      s2_pre      <= pre_c;
    end
  end

  // Qualify the entry and form the result word.
  assign ok      = s2_hist && (s2_empty || (s2_consumed && !s2_pre[PRE_W-1]));
  assign fin_sum = FIN_W'(s2_pre) + FIN_W'(s2_qidx);

  always_ff @(posedge clk) begin
    if (en3) begin
      result.matched      <= ok;
      result.scored_index <= s2_idx;
      if (!ok) begin
        result.match_score <= '0;
        result.match_start <= '0;
        result.match_span  <= '0;
      end else if (s2_empty) begin
        result.match_score <= SCORE_W'(EMPTY_SCORE) - SCORE_W'(s2_idx);
        result.match_start <= '0;
        result.match_span  <= '0;
      end else begin
        result.match_score <= fin_sum[SCORE_W-1:0];
        result.match_start <= START_W'(s2_first);
        result.match_span  <= SPAN_W'(s2_span);
      end
    end
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v         <= 1'b0;
      s2_v         <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (en1) begin
        s1_v <= sum_valid;
      end
      if (en2) begin
        s2_v <= s1_v;
      end
      if (en3) begin
        result.valid <= s2_v;
      end
    end
  end

  // An unmatched entry reports zero score, start and span.
  a_unmatched_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.matched) |->
      (result.match_score == '0 && result.match_start == '0 && result.match_span == '0))
    else $error("unmatched result carries nonzero fields");

  // A summary is taken only when one is waiting.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    sum_pop |=> s1_v)
    else $error("stage one empty after a summary was taken");

  // A stalled result word holds still until it is taken.
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |=>
      (result.valid && $stable(result.matched) && $stable(result.match_score)
       && $stable(result.scored_index)))
    else $error("result word changed while stalled");

endmodule

`default_nettype wire

@@ hw/rtl/fuzzy_subsequence_scorer.sv @@
// Channel   Dir   Handshake      Word
// entry     in    valid/ready    entry_byte, has_byte, entry_end, entry_index
// result    out   valid/ready    matched, match_score, match_start, match_span, scored_index
// apb       in    psel/penable   query_len @0x00, query_bytes_low @0x08, query_bytes_high @0x10
//
// One entry word is taken every cycle while the summary queue is not full; the scan state
// updates with each accepted word. result.valid rises once the end word has passed through
// a two-word summary queue and a three-stage finisher (span and divide-by-ten multiplies,
// score sum, result register).
// Reset is synchronous and clears the scan state, the queue and all valid bits.
// A stalled result stalls the finisher, then fills the queue; entry.ready drops only
// when the queue is full.

`default_nettype none

module fuzzy_subsequence_scorer import fss_pkg::*; #(
  parameter int MAX_ENTRY_LEN = DEF_MAX_ENTRY_LEN,
  parameter int HISTORY_LIMIT = DEF_HISTORY_LIMIT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  fss_in_if.sink                     entry,
  fss_out_if.source                  result,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  localparam int SUM_W = sum_width(MAX_ENTRY_LEN);

  logic [QPOS_W-1:0]     query_len;
  logic [APB_DATA_W-1:0] query_low;
  logic [APB_DATA_W-1:0] query_high;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  wr_en;
  qbytes_t               query_bytes;

  logic             sum_push;
  logic [SUM_W-1:0] sum_in;
  logic             sum_full;
  logic             sum_pop;
  logic [SUM_W-1:0] sum_out;
  logic             sum_valid;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_len  <= '0;
      query_low  <= '0;
      query_high <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_QUERY_LEN:  query_len  <= pwdata[QPOS_W-1:0];
        REG_QUERY_LOW:  query_low  <= pwdata;
        REG_QUERY_HIGH: query_high <= pwdata;
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      REG_QUERY_LEN:  prdata = APB_DATA_W'(query_len);
      REG_QUERY_LOW:  prdata = query_low;
      REG_QUERY_HIGH: prdata = query_high;
      default:        prdata = '0;
    endcase
  end

  assign query_bytes = {query_high, query_low};

  // Byte scanner.
  fss_front #(
    .MAX_ENTRY_LEN (MAX_ENTRY_LEN),
    .HISTORY_LIMIT (HISTORY_LIMIT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .entry       (entry),
    .query_len   (query_len),
    .query_bytes (query_bytes),
    .sum_full    (sum_full),
    .sum_push    (sum_push),
    .sum_data    (sum_in)
  );

  // Summary queue between scanner and finisher.
  fss_queue #(
    .WIDTH (SUM_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (sum_push),
    .push_data (sum_in),
    .full      (sum_full),
    .pop       (sum_pop),
    .pop_data  (sum_out),
    .not_empty (sum_valid)
  );

  // Score finisher.
  fss_back #(
    .MAX_ENTRY_LEN (MAX_ENTRY_LEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .sum_valid (sum_valid),
    .sum_data  (sum_out),
    .sum_pop   (sum_pop),
    .result    (result)
  );

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import fss_pkg::*;

  // One expected score word, laid out like the result channel.
  typedef struct packed {
    logic                      matched;
    logic signed [SCORE_W-1:0] score;
    logic [START_W-1:0]        start;
    logic [SPAN_W-1:0]         span;
    logic [IDX_W-1:0]          index;
  } score_rec_t;

  localparam int MAX_LEN       = DEF_MAX_ENTRY_LEN;
  localparam int HIST_LEN      = DEF_HISTORY_LIMIT;
  localparam int IDX_MAX       = (1 << IDX_W) - 1;
  localparam int RANDOM_WORDS  = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int GAP_PCT       = 18;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  fss_in_if  entry_bus ();
  fss_out_if result_bus ();

  fuzzy_subsequence_scorer uut (
    .clk     (clk),
    .rst     (rst),
    .entry   (entry_bus),
    .result  (result_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Mirror of the query registers.
  logic [QPOS_W-1:0] q_len_reg = '0;
  logic [63:0]       q_lo_reg  = '0;
  logic [63:0]       q_hi_reg  = '0;

  // Mirror of the scan state for the entry in progress.
  int          scan_pos  = 0;
  bit          run_on    = 1'b0;
  int          run_cnt   = 0;
  int          run_best  = 0;
  int          hit_first = -1;
  int          hit_last  = -1;
  int          acc_score = 0;
  logic [7:0]  prev_char = '0;
  int          n_bytes   = 0;

  score_rec_t  score_q[$];
  logic [7:0]  ent_buf[$];
  int          err_count = 0;
  bit          gaps_on   = 1'b1;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [7:0] fold_lower(input logic [7:0] c);
    return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + FOLD_OFFSET : c;
  endfunction

  function automatic bit word_break(input logic [7:0] c);
    return c == CH_SPACE || c == CH_SLASH || c == CH_DASH || c == CH_UNDER;
  endfunction

  function automatic logic [7:0] query_char(input int pos);
    return (pos < 8) ? q_lo_reg[pos*8 +: 8] : q_hi_reg[(pos-8)*8 +: 8];
  endfunction

  function automatic void clear_scan();
    scan_pos  = 0;
    run_on    = 1'b0;
    run_cnt   = 0;
    run_best  = 0;
    hit_first = -1;
    hit_last  = -1;
    acc_score = 0;
    prev_char = '0;
    n_bytes   = 0;
  endfunction

  // Advance the scan by one accepted word and queue a score at entry end.
  function automatic void score_word(input logic [7:0] b, input logic hb, input logic eo,
                                     input logic [IDX_W-1:0] ix);
    int         alen;
    int         best;
    int         sp;
    int         pre;
    int         idx_val;
    logic [7:0] qc;
    score_rec_t r;
    alen = (q_len_reg > QUERY_BYTES) ? QUERY_BYTES : int'(q_len_reg);
    idx_val = int'(ix);
    if (hb) begin
      if (n_bytes < MAX_LEN && scan_pos < alen) begin
        qc = query_char(scan_pos);
        if (fold_lower(b) == fold_lower(qc)) begin
          if (hit_first < 0) hit_first = n_bytes;
          hit_last = n_bytes;
          if (run_on) begin
            run_cnt++;
            acc_score += RUN_BONUS;
          end else begin
            run_cnt = 1;
            run_on = 1'b1;
          end
          if (n_bytes == 0 || word_break(prev_char)) acc_score += SEP_BONUS;
          if (b == qc) acc_score += CASE_BONUS;
          acc_score += HIT_POINTS;
          scan_pos++;
        end else begin
          if (run_cnt > run_best) run_best = run_cnt;
          run_cnt = 0;
          run_on = 1'b0;
        end
      end
      prev_char = b;
      if (n_bytes < MAX_LEN) n_bytes++;
    end
    if (eo) begin
      r = '0;
      r.index = ix;
      if (idx_val < HIST_LEN) begin
        if (alen == 0) begin
          r.matched = 1'b1;
          r.score = SCORE_W'(EMPTY_SCORE - idx_val);
        end else if (scan_pos >= alen) begin
          best = (run_cnt > run_best) ? run_cnt : run_best;
          sp = hit_last - hit_first + 1;
          pre = acc_score + BEST_RUN_MULT * best - sp / 2 - n_bytes / 10;
          if (pre >= 0) begin
            r.matched = 1'b1;
            r.score = SCORE_W'(pre + idx_val / 10);
            r.start = START_W'(hit_first);
            r.span = SPAN_W'(sp);
          end
        end
      end
      score_q.push_back(r);
      clear_scan();
    end
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      err_count++;
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Track accepted entry words and check every score word that leaves.
  always @(posedge clk) begin : monitor
    score_rec_t want;
    if (!rst) begin
      if (entry_bus.valid && entry_bus.ready)
        score_word(entry_bus.entry_byte, entry_bus.has_byte, entry_bus.entry_end,
                   entry_bus.entry_index);
      if (result_bus.valid && result_bus.ready) begin
        if (score_q.size() == 0) begin
          err_count++;
          $display("%0t ns: score word with none expected, expected nothing, got index %0d",
                   $time, result_bus.scored_index);
        end else begin
          want = score_q.pop_front();
          check_field("matched", int'(want.matched), int'(result_bus.matched));
          check_field("match_score", int'(want.score), int'(result_bus.match_score));
          check_field("match_start", int'(want.start), int'(result_bus.match_start));
          check_field("match_span", int'(want.span), int'(result_bus.match_span));
          check_field("scored_index", int'(want.index), int'(result_bus.scored_index));
        end
      end
    end
  end

  // Score sink: stalls at random while gaps are enabled.
  initial begin
    result_bus.ready = 1'b1;
    forever begin
      @(negedge clk);
      result_bus.ready <= !gaps_on || ($urandom_range(0, 99) >= GAP_PCT);
    end
  end

  // Send one entry word; starts and returns at a falling edge.
  task automatic send_word(input logic [7:0] b, input logic hb, input logic eo,
                           input logic [IDX_W-1:0] ix);
    while (gaps_on && $urandom_range(0, 99) < GAP_PCT) begin
      entry_bus.valid <= 1'b0;
      @(negedge clk);
    end
    entry_bus.valid       <= 1'b1;
    entry_bus.entry_byte  <= b;
    entry_bus.has_byte    <= hb;
    entry_bus.entry_end   <= eo;
    entry_bus.entry_index <= ix;
    @(posedge clk);
    while (!entry_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Send the buffered entry, ending on its last byte or on a word of its own.
  task automatic send_entry(input logic [IDX_W-1:0] ix, input bit sep_end);
    int n;
    int i;
    n = ent_buf.size();
    for (i = 0; i < n; i++) begin
      if (i == n - 1 && !sep_end)
        send_word(ent_buf[i], 1'b1, 1'b1, ix);
      else
        send_word(ent_buf[i], 1'b1, 1'b0, IDX_W'($urandom_range(0, IDX_MAX)));
    end
    if (sep_end || n == 0) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1, ix);
  endtask

  task automatic append_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) ent_buf.push_back(s[i]);
  endtask

  task automatic load_text(input string s);
    ent_buf.delete();
    append_text(s);
  endtask

  // Lower valid, wait for every expected score word, then let the pipe drain.
  task automatic wait_idle();
    entry_bus.valid <= 1'b0;
    @(posedge clk);
    while (score_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // APB write: setup then access, taken at the edge where pready is high.
  // The bus then returns to idle before the next transfer.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_QUERY_LEN:  q_len_reg = value[QPOS_W-1:0];
      REG_QUERY_LOW:  q_lo_reg  = value;
      REG_QUERY_HIGH: q_hi_reg  = value;
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_query(input string s, input logic [63:0] len_word);
    logic [63:0] lo;
    logic [63:0] hi;
    int          i;
    lo = '0;
    hi = '0;
    for (i = 0; i < s.len() && i < QUERY_BYTES; i++) begin
      if (i < 8) lo[i*8 +: 8] = s[i];
      else hi[(i-8)*8 +: 8] = s[i];
    end
    write_reg(REG_QUERY_LOW, lo);
    write_reg(REG_QUERY_HIGH, hi);
    write_reg(REG_QUERY_LEN, len_word);
  endtask

  // Mostly a small alphabet so queries hit often, plus separators and any byte.
  function automatic logic [7:0] rand_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 8'("a" + $urandom_range(0, 5));
    if (r < 70) return 8'("A" + $urandom_range(0, 5));
    if (r < 82) begin
      case ($urandom_range(0, 3))
        0: return CH_SPACE;
        1: return CH_SLASH;
        2: return CH_DASH;
        default: return CH_UNDER;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return c + FOLD_OFFSET;
    if (c >= CH_UPPER_A + FOLD_OFFSET && c <= CH_UPPER_Z + FOLD_OFFSET)
      return c - FOLD_OFFSET;
    return c;
  endfunction

  // With an empty query every entry scores 100 minus its index, unless out of history.
  task automatic test_empty_query();
    load_text("abc");
    send_entry(0, 1'b0);
    ent_buf.delete();
    send_entry(IDX_W'(HIST_LEN - 1), 1'b1);
    load_text("x");
    send_entry(IDX_W'(HIST_LEN), 1'b0);
    ent_buf.delete();
    send_entry(IDX_W'(IDX_MAX), 1'b1);
  endtask

  // Case folding, word-start bonus, incomplete match and an ignored word.
  task automatic test_case_and_breaks();
    wait_idle();
    set_query("aB", 2);
    load_text("AB");
    send_entry(10, 1'b0);
    load_text("x-a_b");
    send_entry(123, 1'b1);
    load_text("ba");
    send_entry(7, 1'b0);
    send_word("a", 1'b1, 1'b0, 0);
    send_word(8'h00, 1'b0, 1'b0, 13'h1555);
    send_word("b", 1'b1, 1'b1, 42);
  endtask

  // A zero byte is an ordinary character in both the query and the entry.
  task automatic test_zero_bytes();
    wait_idle();
    write_reg(REG_QUERY_LOW, 64'h0000_0000_0000_4100);
    write_reg(REG_QUERY_LEN, 2);
    ent_buf = '{8'h00, 8'h61};
    send_entry(1, 1'b0);
    ent_buf = '{8'hFF, 8'h41, 8'h00, 8'h41};
    send_entry(2, 1'b1);
    ent_buf = '{8'h41, 8'h00};
    send_entry(3, 1'b0);
  endtask

  // Sixteen-byte queries, including a length above sixteen and all-ones bytes.
  task automatic test_full_query();
    wait_idle();
    set_query("a_b_c_d_e_f_g_h_", 31);
    load_text("a_b_c_d_e_f_g_h_");
    send_entry(4000, 1'b0);
    load_text("A_B_C_D_E_F_G_H");
    send_entry(5, 1'b0);
    wait_idle();
    write_reg(REG_QUERY_HIGH, '1);
    write_reg(REG_QUERY_LEN, 64'hFFFF_FFFF_FFFF_FFF0);
    load_text("a_b_c_d_");
    repeat (8) ent_buf.push_back(8'hFF);
    send_entry(77, 1'b0);
    wait_idle();
    write_reg(REG_QUERY_LOW, '1);
    ent_buf.delete();
    repeat (QUERY_BYTES) ent_buf.push_back(8'hFF);
    send_entry(IDX_W'(HIST_LEN - 1), 1'b1);
  endtask

  // Late match far into an entry, and a hit past the saturated length.
  task automatic test_long_entry();
    wait_idle();
    set_query("a_b_c_d_e_f_g_h_", 16);
    ent_buf.delete();
    repeat (2047) ent_buf.push_back("x");
    append_text(" a_b_c_d_e_f_g_h_");
    send_entry(IDX_W'(HIST_LEN - 1), 1'b0);
    wait_idle();
    set_query("z", 1);
    ent_buf.delete();
    repeat (MAX_LEN + 1) ent_buf.push_back("y");
    append_text("zyyy");
    send_entry(0, 1'b0);
  endtask

  // Random queries and entries, mostly built around the query with noise between.
  task automatic test_random_entries();
    int          words;
    int          phase;
    int          goal;
    int          qlen;
    int          alen;
    int          r;
    int          i;
    int          n;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] len_word;
    logic [7:0]  c;
    logic [IDX_W-1:0] ix;
    bit          sep;
    words = 0;
    phase = 0;
    while (words < RANDOM_WORDS) begin
      wait_idle();
      // The first two phases run with no stalls on either side.
      gaps_on = (phase >= 2);
      r = $urandom_range(0, 99);
      if (r < 8) qlen = 0;
      else if (r < 70) qlen = $urandom_range(1, 4);
      else if (r < 85) qlen = $urandom_range(5, 8);
      else if (r < 93) qlen = QUERY_BYTES;
      else qlen = $urandom_range(QUERY_BYTES + 1, 31);
      for (i = 0; i < 8; i++) begin
        lo[i*8 +: 8] = rand_char();
        hi[i*8 +: 8] = rand_char();
      end
      len_word = {$urandom, $urandom};
      len_word[QPOS_W-1:0] = QPOS_W'(qlen);
      write_reg(REG_QUERY_LOW, lo);
      write_reg(REG_QUERY_HIGH, hi);
      write_reg(REG_QUERY_LEN, len_word);
      alen = (qlen > QUERY_BYTES) ? QUERY_BYTES : qlen;
      goal = words + $urandom_range(30, 70);
      while (words < goal && words < RANDOM_WORDS) begin
        ent_buf.delete();
        if (alen > 0 && $urandom_range(0, 99) < 75) begin
          for (i = 0; i < alen; i++) begin
            // An occasional dropped query byte gives a broken match.
            if ($urandom_range(0, 99) < 5) continue;
            n = ($urandom_range(0, 99) < 50) ? 0 : $urandom_range(1, 2);
            repeat (n) ent_buf.push_back(rand_char());
            c = query_char(i);
            if ($urandom_range(0, 99) < 30) c = flip_case(c);
            ent_buf.push_back(c);
          end
          repeat ($urandom_range(0, 2)) ent_buf.push_back(rand_char());
        end else begin
          repeat ($urandom_range(0, 8)) ent_buf.push_back(rand_char());
        end
        r = $urandom_range(0, 99);
        if (r < 80) ix = IDX_W'($urandom_range(0, HIST_LEN - 1));
        else if (r < 92) ix = IDX_W'($urandom_range(HIST_LEN - 10, HIST_LEN + 10));
        else ix = IDX_W'($urandom_range(0, IDX_MAX));
        sep = ($urandom_range(0, 99) < 30);
        if ($urandom_range(0, 99) < 10)
          send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, IDX_W'($urandom_range(0, IDX_MAX)));
        send_entry(ix, sep);
        words += ent_buf.size() + ((sep || ent_buf.size() == 0) ? 1 : 0);
      end
      phase++;
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst                   = 1'b1;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    entry_bus.valid       = 1'b0;
    entry_bus.entry_byte  = '0;
    entry_bus.has_byte    = 1'b0;
    entry_bus.entry_end   = 1'b0;
    entry_bus.entry_index = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_query();
    test_case_and_breaks();
    test_zero_bytes();
    test_full_query();
    test_long_entry();
    test_random_entries();
    wait_idle();

    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ fuzzy_subsequence_scorer.f @@
hw/rtl/fss_pkg.sv
hw/rtl/fss_if.sv
hw/rtl/fss_front.sv
hw/rtl/fss_queue.sv
hw/rtl/fss_back.sv
hw/rtl/fuzzy_subsequence_scorer.sv
bench/tb.sv
